### hdl/ibb_pkg.sv
// ibb_pkg: types, constants and helper functions shared by the instanced box bounds block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ibb_pkg;

   // fixed point format and datapath widths
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int SUM_W     = PROD_W + 2;

   // job queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // row role of a transaction within its instance
   localparam logic [1:0] ROW_X = 2'd0;
   localparam logic [1:0] ROW_Y = 2'd1;
   localparam logic [1:0] ROW_Z = 2'd2;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_XY = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Z  = 3'd7;
   localparam int CSR_DATA_W = 64;

   // empty-bounds sentinels
   localparam logic signed [DATA_W-1:0] BOUND_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] BOUND_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic signed [DATA_W-1:0] coef_a;
      logic signed [DATA_W-1:0] coef_b;
      logic signed [DATA_W-1:0] coef_c;
      logic signed [DATA_W-1:0] coef_t;
      logic                     is_last;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] low_x;
      logic signed [DATA_W-1:0] low_y;
      logic signed [DATA_W-1:0] low_z;
      logic signed [DATA_W-1:0] high_x;
      logic signed [DATA_W-1:0] high_y;
      logic signed [DATA_W-1:0] high_z;
      logic                     empty_res;
   } rsp_type;

   // classified row handed from front to back
   typedef struct packed {
      req_type    req;
      logic [1:0] row;
   } job_type;

   // queue status seen by the top level
   typedef struct packed {
      logic push_ready;
      logic pop_valid;
   } q_stat_type;

   // configuration register file
   typedef struct packed {
      logic signed [DATA_W-1:0] box_min_x;
      logic signed [DATA_W-1:0] box_min_y;
      logic signed [DATA_W-1:0] box_min_z;
      logic signed [DATA_W-1:0] box_max_x;
      logic signed [DATA_W-1:0] box_max_y;
      logic signed [DATA_W-1:0] box_max_z;
      logic signed [DATA_W-1:0] center_x;
      logic signed [DATA_W-1:0] center_y;
      logic signed [DATA_W-1:0] center_z;
   } cfg_type;

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [DATA_W-1:0] clamp32(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi_lim;
      logic signed [SUM_W-1:0] lo_lim;
      hi_lim = $signed({{(SUM_W-DATA_W){1'b0}}, BOUND_MAX});
      lo_lim = $signed({{(SUM_W-DATA_W){1'b1}}, BOUND_MIN});
      if (v > hi_lim) begin
         return BOUND_MAX;
      end else if (v < lo_lim) begin
         return BOUND_MIN;
      end
      return v[DATA_W-1:0];
   endfunction

   // saturating signed 32-bit add
   function automatic logic signed [DATA_W-1:0] sat_add32(input logic signed [DATA_W-1:0] a,
                                                          input logic signed [DATA_W-1:0] b);
      logic [DATA_W:0] s;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) begin
         return s[DATA_W] ? BOUND_MIN : BOUND_MAX;
      end
      return s[DATA_W-1:0];
   endfunction

endpackage

`default_nettype wire

### hdl/ibb_front.sv
// ibb_front: accepts request transactions and tags each with its row role in the instance.
// Depends on ibb_pkg; feeds ibb_queue.
`default_nettype none

module ibb_front (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  ibb_pkg::req_type req_data,
   input  wire              push_ready,
   output logic             push_valid,
   output ibb_pkg::job_type push_job
);
   import ibb_pkg::*;

   logic [1:0] row_ff, row_in;
   logic       accept;

   assign req_ready     = push_ready;
   assign accept        = req_valid && push_ready;
   assign push_valid    = req_valid;
   assign push_job.req  = req_data;
   assign push_job.row  = row_ff;

   // row counter: x, y, z, back to x; the last row of a job restarts it
   always_comb begin
      row_in = row_ff;
      if (accept) begin
         if (req_data.is_last || row_ff == ROW_Z) begin
            row_in = ROW_X;
         end else begin
            row_in = row_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= ROW_X;
      end else begin
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

### hdl/ibb_queue.sv
// ibb_queue: short FIFO of classified rows between front and back.
// Depends on ibb_pkg for the entry type and depth.
`default_nettype none

module ibb_queue (
   input  wire              clock,
   input  wire              reset,
   input  wire              push_valid,
   input  ibb_pkg::job_type push_job,
   input  wire              pop,
   output ibb_pkg::q_stat_type stat,
   output ibb_pkg::job_type pop_job
);
   import ibb_pkg::*;

   job_type              slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 push;
   logic                 pull;

   assign stat.push_ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign stat.pop_valid  = (count_ff != '0);
   assign push            = push_valid && stat.push_ready;
   assign pull            = pop && stat.pop_valid;
   assign pop_job         = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? Q_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pull ? Q_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pull) begin
         count_in = count_ff + 1'b1;
      end else if (pull && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### hdl/ibb_back.sv
// ibb_back: evaluates each row on the box corners, merges instance bounds, forms the result.
// Depends on ibb_pkg; pulls from ibb_queue, drives the response channel.
`default_nettype none

module ibb_back (
   input  wire              clock,
   input  wire              reset,
   input  ibb_pkg::cfg_type cfg,
   input  wire              pop_valid,
   input  ibb_pkg::job_type pop_job,
   output logic             pop,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output ibb_pkg::rsp_type rsp_data
);
   import ibb_pkg::*;

   typedef struct packed {
      logic [1:0] row;
      logic       last;
   } tag_type;

   logic adv;

   // stage 1: six products, one per coefficient and box extreme
   logic                     v1_ff;
   tag_type                  tag1_ff;
   logic signed [DATA_W-1:0] t1_ff;
   logic signed [PROD_W-1:0] pa_lo_ff, pa_hi_ff, pb_lo_ff, pb_hi_ff, pc_lo_ff, pc_hi_ff;

   // stage 2: per-axis min and max product
   logic                     v2_ff;
   tag_type                  tag2_ff;
   logic signed [DATA_W-1:0] t2_ff;
   logic signed [PROD_W-1:0] mna_ff, mxa_ff, mnb_ff, mxb_ff, mnc_ff, mxc_ff;

   // stage 3: exact corner sums
   logic                     v3_ff;
   tag_type                  tag3_ff;
   logic signed [DATA_W-1:0] t3_ff;
   logic signed [SUM_W-1:0]  sum_lo_ff, sum_hi_ff;

   // stage 4: row min and max in Q format
   logic                     v4_ff;
   tag_type                  tag4_ff;
   logic signed [DATA_W-1:0] lo4_ff, hi4_ff;

   // accumulation state
   logic signed [DATA_W-1:0] pend_ff [4];
   logic signed [DATA_W-1:0] run_min_ff [3];
   logic signed [DATA_W-1:0] run_max_ff [3];
   logic                     seen_ff;
   logic signed [DATA_W-1:0] mrg_min [3];
   logic signed [DATA_W-1:0] mrg_max [3];
   logic signed [DATA_W-1:0] cand_min [3];
   logic signed [DATA_W-1:0] cand_max [3];
   logic                     mrg_seen;

   // stage 5: raw job bounds
   logic                     v5_ff;
   logic signed [DATA_W-1:0] res_min_ff [3];
   logic signed [DATA_W-1:0] res_max_ff [3];
   logic                     res_seen_ff;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   logic signed [SUM_W-1:0] sh_lo, sh_hi, t3_ext;

   // whole back end moves unless a result sits unread
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign pop       = pop_valid && adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= pop_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff && tag4_ff.last;
      end
   end

   // products against box extremes
   always_ff @(posedge clock) begin
      if (adv) begin
         tag1_ff.row  <= pop_job.row;
         tag1_ff.last <= pop_job.req.is_last;
         t1_ff        <= pop_job.req.coef_t;
         pa_lo_ff     <= $signed(pop_job.req.coef_a) * $signed(cfg.box_min_x);
         pa_hi_ff     <= $signed(pop_job.req.coef_a) * $signed(cfg.box_max_x);
         pb_lo_ff     <= $signed(pop_job.req.coef_b) * $signed(cfg.box_min_y);
         pb_hi_ff     <= $signed(pop_job.req.coef_b) * $signed(cfg.box_max_y);
         pc_lo_ff     <= $signed(pop_job.req.coef_c) * $signed(cfg.box_min_z);
         pc_hi_ff     <= $signed(pop_job.req.coef_c) * $signed(cfg.box_max_z);
      end
   end

   // terms are separable: corner extremes come from per-axis extremes
   always_ff @(posedge clock) begin
      if (adv) begin
         tag2_ff <= tag1_ff;
         t2_ff   <= t1_ff;
         mna_ff  <= (pa_lo_ff < pa_hi_ff) ? pa_lo_ff : pa_hi_ff;
         mxa_ff  <= (pa_lo_ff < pa_hi_ff) ? pa_hi_ff : pa_lo_ff;
         mnb_ff  <= (pb_lo_ff < pb_hi_ff) ? pb_lo_ff : pb_hi_ff;
         mxb_ff  <= (pb_lo_ff < pb_hi_ff) ? pb_hi_ff : pb_lo_ff;
         mnc_ff  <= (pc_lo_ff < pc_hi_ff) ? pc_lo_ff : pc_hi_ff;
         mxc_ff  <= (pc_lo_ff < pc_hi_ff) ? pc_hi_ff : pc_lo_ff;
      end
   end

   // exact three-term sums
   always_ff @(posedge clock) begin
      if (adv) begin
         tag3_ff   <= tag2_ff;
         t3_ff     <= t2_ff;
         sum_lo_ff <= $signed({{2{mna_ff[PROD_W-1]}}, mna_ff})
                    + $signed({{2{mnb_ff[PROD_W-1]}}, mnb_ff})
                    + $signed({{2{mnc_ff[PROD_W-1]}}, mnc_ff});
         sum_hi_ff <= $signed({{2{mxa_ff[PROD_W-1]}}, mxa_ff})
                    + $signed({{2{mxb_ff[PROD_W-1]}}, mxb_ff})
                    + $signed({{2{mxc_ff[PROD_W-1]}}, mxc_ff});
      end
   end

   // floor to Q format, add translation, clamp
   assign t3_ext = $signed({{(SUM_W-DATA_W){t3_ff[DATA_W-1]}}, t3_ff});
   assign sh_lo  = (sum_lo_ff >>> FRAC_BITS) + t3_ext;
   assign sh_hi  = (sum_hi_ff >>> FRAC_BITS) + t3_ext;

   always_ff @(posedge clock) begin
      if (adv) begin
         tag4_ff <= tag3_ff;
         lo4_ff  <= clamp32(sh_lo);
         hi4_ff  <= clamp32(sh_hi);
      end
   end

   // merge a completed instance into the running bounds
   always_comb begin
      cand_min[0] = pend_ff[0];
      cand_max[0] = pend_ff[1];
      cand_min[1] = pend_ff[2];
      cand_max[1] = pend_ff[3];
      cand_min[2] = lo4_ff;
      cand_max[2] = hi4_ff;
      mrg_seen    = seen_ff;
      for (int i = 0; i < 3; i++) begin
         mrg_min[i] = run_min_ff[i];
         mrg_max[i] = run_max_ff[i];
      end
      if (v4_ff && tag4_ff.row == ROW_Z) begin
         mrg_seen = 1'b1;
         for (int i = 0; i < 3; i++) begin
            if (cand_min[i] < run_min_ff[i]) begin
               mrg_min[i] = cand_min[i];
            end
            if (cand_max[i] > run_max_ff[i]) begin
               mrg_max[i] = cand_max[i];
            end
         end
      end
   end

   // running bounds: updated when a z row completes an instance, cleared after the last row
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            run_min_ff[i] <= BOUND_MAX;
            run_max_ff[i] <= BOUND_MIN;
         end
      end else if (adv && v4_ff) begin
         if (tag4_ff.last) begin
            seen_ff <= 1'b0;
            for (int i = 0; i < 3; i++) begin
               run_min_ff[i] <= BOUND_MAX;
               run_max_ff[i] <= BOUND_MIN;
            end
         end else begin
            seen_ff <= mrg_seen;
            for (int i = 0; i < 3; i++) begin
               run_min_ff[i] <= mrg_min[i];
               run_max_ff[i] <= mrg_max[i];
            end
         end
      end
   end

   // pending x and y row bounds
   always_ff @(posedge clock) begin
      if (adv && v4_ff) begin
         case (tag4_ff.row)
            ROW_X: begin
               pend_ff[0] <= lo4_ff;
               pend_ff[1] <= hi4_ff;
            end
            ROW_Y: begin
               pend_ff[2] <= lo4_ff;
               pend_ff[3] <= hi4_ff;
            end
            default: ;
         endcase
      end
   end

   // capture job bounds on the last row
   always_ff @(posedge clock) begin
      if (adv) begin
         res_seen_ff <= mrg_seen;
         for (int i = 0; i < 3; i++) begin
            res_min_ff[i] <= mrg_min[i];
            res_max_ff[i] <= mrg_max[i];
         end
      end
   end

   // centre offset, skipped for an empty job
   always_comb begin
      rsp_data_in.low_x     = res_min_ff[0];
      rsp_data_in.low_y     = res_min_ff[1];
      rsp_data_in.low_z     = res_min_ff[2];
      rsp_data_in.high_x    = res_max_ff[0];
      rsp_data_in.high_y    = res_max_ff[1];
      rsp_data_in.high_z    = res_max_ff[2];
      rsp_data_in.empty_res = !res_seen_ff;
      if (res_seen_ff) begin
         rsp_data_in.low_x  = sat_add32(res_min_ff[0], cfg.center_x);
         rsp_data_in.low_y  = sat_add32(res_min_ff[1], cfg.center_y);
         rsp_data_in.low_z  = sat_add32(res_min_ff[2], cfg.center_z);
         rsp_data_in.high_x = sat_add32(res_max_ff[0], cfg.center_x);
         rsp_data_in.high_y = sat_add32(res_max_ff[1], cfg.center_y);
         rsp_data_in.high_z = sat_add32(res_max_ff[2], cfg.center_z);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

### hdl/instanced_box_bounds.sv
// instanced_box_bounds: top level; configuration registers, front, job queue and back end.
// Depends on ibb_pkg, ibb_front, ibb_queue and ibb_back.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  req_data  (ibb_pkg::req_type), one transform row
//   rsp_     out        rsp_valid/rsp_ready  rsp_data  (ibb_pkg::rsp_type), job bounds
//   csr_     in         csr_valid/csr_ready  csr_index, csr_data (register write)
//
// One row is accepted per cycle while req_ready is high; a result passes from its last
// row through one queue entry and six back-end registers around the multipliers.
// Synchronous active-high reset clears registers, job state and the queue.
// While a result waits unread the back end holds; the 4-entry queue then fills
// and req_ready drops. csr_ready is always high.
`default_nettype none

module instanced_box_bounds (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  ibb_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output ibb_pkg::rsp_type                    rsp_data,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [ibb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [ibb_pkg::CSR_DATA_W-1:0]       csr_data
);
   import ibb_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   q_stat_type q_stat;
   logic       push_valid;
   job_type    push_job;
   job_type    pop_job;
   logic       pop;

   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BOX_MIN_X: cfg_in.box_min_x = csr_data[DATA_W-1:0];
            CSR_BOX_MIN_Y: cfg_in.box_min_y = csr_data[DATA_W-1:0];
            CSR_BOX_MIN_Z: cfg_in.box_min_z = csr_data[DATA_W-1:0];
            CSR_BOX_MAX_X: cfg_in.box_max_x = csr_data[DATA_W-1:0];
            CSR_BOX_MAX_Y: cfg_in.box_max_y = csr_data[DATA_W-1:0];
            CSR_BOX_MAX_Z: cfg_in.box_max_z = csr_data[DATA_W-1:0];
            CSR_CENTER_XY: begin
               cfg_in.center_x = csr_data[DATA_W-1:0];
               cfg_in.center_y = csr_data[2*DATA_W-1:DATA_W];
            end
            CSR_CENTER_Z:  cfg_in.center_z = csr_data[DATA_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ibb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_ready (q_stat.push_ready),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   ibb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .stat       (q_stat),
      .pop_job    (pop_job)
   );

   ibb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (q_stat.pop_valid),
      .pop_job   (pop_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // no result can be pending right after reset
   a_reset_quiet: assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid right after reset");

   // the row after a last row starts a new instance
   a_row_restart: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.is_last) |=> (!push_valid || push_job.row == ROW_X))
      else $error("row counter not restarted after last row");

   // the front never tags a row past z
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (push_job.row == ROW_X || push_job.row == ROW_Y || push_job.row == ROW_Z))
      else $error("row tag out of range");

   // the back end only pulls from a non-empty queue
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_stat.pop_valid)
      else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire
